>>> hdl/setsu_pkg.sv
package setsu_pkg;

    localparam int NUM_EVENTS = 32;
    localparam int IDX_W      = $clog2(NUM_EVENTS);
    localparam int CNT_W      = $clog2(NUM_EVENTS + 1);
    localparam int CPM_W      = 20;

    localparam logic [31:0]      MAX_CLOCK = 32'd4194304;
    localparam logic [CPM_W-1:0] CPM_RESET = 20'd1000;

    typedef enum logic [3:0] {
        ACT_CLEAR    = 4'd0,
        ACT_RELOAD   = 4'd1,
        ACT_PROGRESS = 4'd2,
        ACT_SET      = 4'd3,
        ACT_SET_MS   = 4'd4,
        ACT_CANCEL   = 4'd5,
        ACT_QUERY    = 4'd6,
        ACT_FORCE    = 4'd7,
        ACT_CONSUME  = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_NONE  = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef struct packed {
        t_action     action;
        logic [4:0]  event_id;
        logic [31:0] delay;
        logic        absolute;
        logic        has_callback;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  fired_id;
        logic        fired_has_callback;
        logic        is_active;
        logic [31:0] remaining;
        logic [31:0] base_clock;
        logic [31:0] remain_clock;
        logic        last;
    } t_out;

    typedef struct packed {
        logic             v;
        logic             fire;
        logic [IDX_W-1:0] id;
        logic [31:0]      cnt;
    } t_entry;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_SUB,
        CELL_ROTATE,
        CELL_COMPACT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic             phase;
        logic             found;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] new_id;
        logic [31:0]      new_cnt;
        logic [31:0]      base;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SET,
        ST_INS,
        ST_OP,
        ST_SUB,
        ST_MIN,
        ST_FIRE,
        ST_COMPACT,
        ST_ACK
    } t_state;

endpackage

>>> hdl/setsu_cell.sv
module setsu_cell
    import setsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell_ctl        i_ctl,
    input  t_entry           i_left,
    input  logic             i_left_take,
    input  t_entry           i_right,
    output t_entry           o_entry,
    output logic             o_take
);

    t_entry      r_ent;
    t_entry      n_ent;
    logic        w_take;
    logic [31:0] w_sub;
    logic        w_lower;

    assign w_take  = !r_ent.v || ($signed(i_ctl.new_cnt) < $signed(r_ent.cnt));
    assign w_sub   = r_ent.cnt - i_ctl.base;
    assign w_lower = (i_idx[0] == i_ctl.phase);
    assign o_take  = w_take;
    assign o_entry = r_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_ctl.op)
            CELL_CLEAR: begin
                n_ent.v    = 1'b0;
                n_ent.fire = 1'b0;
            end
            CELL_REMOVE: begin
                if (i_ctl.found && (i_idx >= i_ctl.pos)) begin
                    n_ent = i_right;
                end
            end
            CELL_INSERT: begin
                if (w_take) begin
                    if (i_left_take) begin
                        n_ent = i_left;
                    end else begin
                        n_ent.v    = 1'b1;
                        n_ent.fire = 1'b0;
                        n_ent.id   = i_ctl.new_id;
                        n_ent.cnt  = i_ctl.new_cnt;
                    end
                end
            end
            CELL_SUB: begin
                n_ent.cnt  = w_sub;
                n_ent.fire = r_ent.v && !($signed(w_sub) > 32'sd0);
            end
            CELL_ROTATE: begin
                n_ent = i_right;
            end
            CELL_COMPACT: begin
                if (w_lower) begin
                    if (!r_ent.v && i_right.v) begin
                        n_ent = i_right;
                    end
                end else if (!i_left.v && r_ent.v) begin
                    n_ent = i_left;
                end
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.v    <= 1'b0;
            r_ent.fire <= 1'b0;
        end else begin
            r_ent.v    <= n_ent.v;
            r_ent.fire <= n_ent.fire;
        end
        r_ent.id  <= n_ent.id;
        r_ent.cnt <= n_ent.cnt;
    end

endmodule

>>> hdl/sorted_event_timer_scheduler_unit.sv
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_in_data  (t_in)
// out      output     o_out_valid / i_out_ready o_out_data (t_out)
// cfg      input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item at a time. Most actions pass through an operation state and then the ack state
// that sends the result beat; cancel uses the set state instead, set adds an insert state
// after it, and set in milliseconds first a multiply state. Progress subtracts, then
// walks the cell row three times (minimum, firing, compaction). Reset is synchronous; a full
// result register stalls the walk until the beat is taken.
module sorted_event_timer_scheduler_unit
    import setsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state            r_state;
    t_state            n_state;
    t_in               r_cmd;
    logic [IDX_W-1:0]  r_step;
    logic [31:0]       r_base;
    logic [31:0]       r_budget;
    logic [CNT_W-1:0]  r_count;
    logic [31:0]       r_new;
    logic [31:0]       r_delay;
    logic [31:0]       r_next;
    logic              r_fired;
    logic [31:0]       r_slot_cnt [NUM_EVENTS];
    logic              r_slot_cb  [NUM_EVENTS];
    logic [NUM_EVENTS-1:0] r_slot_ok;
    logic [CPM_W-1:0]  r_cpm;
    t_out              r_out;
    logic              r_ovalid;

    t_entry            w_entry [NUM_EVENTS];
    logic [NUM_EVENTS-1:0] w_take;
    t_entry            w_tail;
    t_entry            w_block;
    t_cell_ctl         w_ctl;
    t_entry            w_head;
    logic              w_acc;
    logic              w_can_emit;
    logic              w_emit;
    t_out              w_emit_data;
    logic              w_advance;
    logic              w_last_step;
    logic              w_id_ok;
    logic [IDX_W-1:0]  w_cidx;
    logic [NUM_EVENTS-1:0] w_match;
    logic              w_found;
    logic [IDX_W-1:0]  w_pos;
    logic              w_later_fire;
    logic [31:0]       w_old_cnt;
    logic [31:0]       w_now;
    logic [31:0]       w_set_cnt;
    logic [31:0]       w_nx;
    logic [51:0]       w_prod;
    logic              w_head_cb;

    assign w_acc       = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_can_emit  = !r_ovalid || i_out_ready;
    assign w_last_step = (r_step == IDX_W'(NUM_EVENTS - 1));
    assign w_head      = w_entry[0];
    assign w_id_ok     = ({27'd0, r_cmd.event_id} < 32'(NUM_EVENTS));
    assign w_cidx      = r_cmd.event_id[IDX_W-1:0];
    assign w_old_cnt   = r_slot_ok[w_cidx] ? r_slot_cnt[w_cidx] : 32'd0;
    assign w_now       = r_base - r_budget;
    assign w_set_cnt   = r_cmd.absolute ? (r_delay + w_now) : (w_old_cnt + r_delay);
    assign w_prod      = {20'd0, r_cmd.delay} * {32'd0, r_cpm};
    assign w_head_cb   = r_slot_ok[w_head.id] ? r_slot_cb[w_head.id] : 1'b0;
    assign w_nx        = (w_head.v && !w_head.fire && ($signed(r_next) >= $signed(w_head.cnt)))
                         ? w_head.cnt : r_next;

    always_comb begin
        w_block      = '0;
        w_block.v    = 1'b1;
        w_pos        = '0;
        w_later_fire = 1'b0;
        for (int i = 0; i < NUM_EVENTS; i++) begin
            w_match[i] = w_entry[i].v && (w_entry[i].id == w_cidx) && w_id_ok;
            if (w_match[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
            if (i > 0) begin
                w_later_fire = w_later_fire | w_entry[i].fire;
            end
        end
        w_found = |w_match;
    end

    for (genvar g = 0; g < NUM_EVENTS; g++) begin : g_cell
        setsu_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_idx       (IDX_W'(g)),
            .i_ctl       (w_ctl),
            .i_left      ((g == 0) ? w_block : w_entry[(g == 0) ? 0 : g - 1]),
            .i_left_take ((g == 0) ? 1'b0 : w_take[(g == 0) ? 0 : g - 1]),
            .i_right     ((g == NUM_EVENTS - 1) ? w_tail
                          : w_entry[(g == NUM_EVENTS - 1) ? g : g + 1]),
            .o_entry     (w_entry[g]),
            .o_take      (w_take[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (i_in_data.action)
                        ACT_SET, ACT_CANCEL: n_state = ST_SET;
                        ACT_SET_MS:          n_state = ST_MUL;
                        ACT_PROGRESS:        n_state = ST_SUB;
                        default:             n_state = ST_OP;
                    endcase
                end
            end
            ST_MUL:  n_state = ST_SET;
            ST_SET: begin
                if ((r_cmd.action == ACT_CANCEL) || !w_id_ok) begin
                    n_state = ST_ACK;
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_INS:  n_state = ST_ACK;
            ST_OP:   n_state = ST_ACK;
            ST_SUB:  n_state = ST_MIN;
            ST_MIN: begin
                if (w_last_step) begin
                    n_state = ST_FIRE;
                end
            end
            ST_FIRE: begin
                if (w_advance && w_last_step) begin
                    n_state = ST_COMPACT;
                end
            end
            ST_COMPACT: begin
                if (w_last_step) begin
                    n_state = r_fired ? ST_IDLE : ST_ACK;
                end
            end
            ST_ACK: begin
                if (w_can_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl         = '0;
        w_ctl.op      = CELL_HOLD;
        w_ctl.phase   = r_step[0];
        w_ctl.found   = w_found;
        w_ctl.pos     = w_pos;
        w_ctl.new_id  = w_cidx;
        w_ctl.new_cnt = r_new;
        w_ctl.base    = r_base;
        w_tail        = '0;
        w_advance     = 1'b0;
        w_emit        = 1'b0;
        w_emit_data   = '0;
        w_emit_data.kind         = KIND_ACK;
        w_emit_data.base_clock   = r_base;
        w_emit_data.remain_clock = r_budget;
        w_emit_data.last         = 1'b1;
        unique case (r_state)
            ST_OP: begin
                if (r_cmd.action == ACT_CLEAR) begin
                    w_ctl.op = CELL_CLEAR;
                end
            end
            ST_SET: begin
                if (w_id_ok) begin
                    w_ctl.op = CELL_REMOVE;
                end
            end
            ST_INS: begin
                if (r_count < CNT_W'(NUM_EVENTS)) begin
                    w_ctl.op = CELL_INSERT;
                end
            end
            ST_SUB: w_ctl.op = CELL_SUB;
            ST_MIN: begin
                w_ctl.op = CELL_ROTATE;
                w_tail   = w_head;
            end
            ST_FIRE: begin
                w_advance = !w_head.fire || w_can_emit;
                w_ctl.op  = w_advance ? CELL_ROTATE : CELL_HOLD;
                w_tail    = w_head.fire ? '0 : w_head;
                w_emit    = w_head.fire && w_can_emit;
                w_emit_data.kind               = KIND_FIRED;
                w_emit_data.fired_id           = 5'(w_head.id);
                w_emit_data.fired_has_callback = w_head_cb;
                w_emit_data.last               = !w_later_fire;
            end
            ST_COMPACT: w_ctl.op = CELL_COMPACT;
            ST_ACK: begin
                w_emit = w_can_emit;
                if (r_cmd.action == ACT_QUERY) begin
                    w_emit_data.kind      = KIND_QUERY;
                    w_emit_data.fired_id  = r_cmd.event_id;
                    w_emit_data.is_active = w_found;
                    w_emit_data.remaining = w_found ? (w_old_cnt - w_now) : 32'hFFFF_FFFF;
                end else if (r_cmd.action == ACT_PROGRESS) begin
                    w_emit_data.kind = KIND_NONE;
                end
            end
            default: begin
                w_ctl.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_base    <= '0;
            r_budget  <= '0;
            r_count   <= '0;
            r_fired   <= 1'b0;
            r_slot_ok <= '0;
            r_cpm     <= CPM_RESET;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && !paddr[2]) begin
                r_cpm <= pwdata[CPM_W-1:0];
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_OP: begin
                    unique case (r_cmd.action)
                        ACT_CLEAR: begin
                            r_slot_ok <= '0;
                            r_count   <= '0;
                            r_base    <= '0;
                            r_budget  <= '0;
                        end
                        ACT_RELOAD: begin
                            r_base   <= (r_count != '0) ? w_head.cnt : MAX_CLOCK;
                            r_budget <= (r_count != '0) ? w_head.cnt : MAX_CLOCK;
                        end
                        ACT_FORCE: begin
                            if ($signed(r_budget) > 32'sd0) begin
                                r_base   <= r_base - r_budget;
                                r_budget <= '0;
                            end
                        end
                        ACT_CONSUME: r_budget <= r_budget - r_cmd.delay;
                        default: r_budget <= r_budget;
                    endcase
                end
                ST_SET: begin
                    if (w_id_ok) begin
                        if (w_found) begin
                            r_count <= r_count - 1'b1;
                        end
                        if (r_cmd.action != ACT_CANCEL) begin
                            r_slot_ok[w_cidx] <= 1'b1;
                        end
                    end
                end
                ST_INS: begin
                    if (r_count < CNT_W'(NUM_EVENTS)) begin
                        r_count <= r_count + 1'b1;
                        if (w_take[0]) begin
                            r_base   <= r_new;
                            r_budget <= r_budget - (r_base - r_new);
                        end
                    end
                end
                ST_SUB: begin
                    r_step  <= '0;
                    r_fired <= 1'b0;
                end
                ST_MIN: begin
                    r_step <= w_last_step ? '0 : r_step + 1'b1;
                    if (w_head.v) begin
                        r_slot_ok[w_head.id] <= 1'b1;
                    end
                    if (w_last_step) begin
                        r_base   <= w_nx;
                        r_budget <= r_budget + w_nx;
                    end
                end
                ST_FIRE: begin
                    if (w_advance) begin
                        r_step <= w_last_step ? '0 : r_step + 1'b1;
                        if (w_head.fire) begin
                            r_fired <= 1'b1;
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                ST_COMPACT: r_step <= w_last_step ? '0 : r_step + 1'b1;
                default: r_step <= r_step;
            endcase
        end
        if (w_acc) begin
            r_cmd   <= i_in_data;
            r_delay <= i_in_data.delay;
        end
        if (r_state == ST_MUL) begin
            r_delay <= w_prod[31:0];
        end
        if (r_state == ST_SUB) begin
            r_next <= MAX_CLOCK;
        end
        if (r_state == ST_MIN) begin
            r_next <= w_nx;
            if (w_head.v) begin
                r_slot_cnt[w_head.id] <= w_head.cnt;
            end
        end
        if ((r_state == ST_SET) && w_id_ok && (r_cmd.action != ACT_CANCEL)) begin
            r_new                <= w_set_cnt;
            r_slot_cnt[w_cidx]   <= w_set_cnt;
            r_slot_cb[w_cidx]    <= r_cmd.has_callback;
        end
        if (w_emit) begin
            r_out <= w_emit_data;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? 32'd0 : {12'd0, r_cpm};

endmodule
